// File: hdl/sat_pkg.sv
package sat_pkg;
  localparam int unsigned IfcW = 32;
  localparam int unsigned AddrW = 64;
  localparam int unsigned PfxW = 8;
  localparam int unsigned LifeW = 32;
  localparam int unsigned EvW = 3;
  localparam int unsigned SlotW = 4;

  localparam logic [EvW-1:0] EV_NONE    = 3'd0;
  localparam logic [EvW-1:0] EV_NEW     = 3'd1;
  localparam logic [EvW-1:0] EV_REMOVED = 3'd2;
  localparam logic [EvW-1:0] EV_UPDATED = 3'd3;
  localparam logic [EvW-1:0] EV_FULL    = 3'd4;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic CFG_AGING_STEP = 1'b0;
  localparam logic CFG_UNLIMITED  = 1'b1;

  typedef struct packed {
    logic             used;
    logic             is_ipv6;
    logic [IfcW-1:0]  ifc;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
    logic [PfxW-1:0]  pfx;
    logic [LifeW-1:0] prf;
    logic [LifeW-1:0] vld;
  } entry_t;

  // operation decoded by the controller; rotate reaches every cell as shift
  typedef struct packed {
    logic             rotate;   // shift ring by one this cycle
    logic             do_tick;
    logic             do_match; // compare key with head cell
    logic             do_clear; // clear head entry
    logic             do_refresh;
    logic             do_insert;
  } cell_ctl_t;
endpackage

// File: hdl/sat_cell.sv
module sat_cell
  import sat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift,
  input  entry_t     d,
  output entry_t     q
);
  entry_t q_r;
  logic   used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift) begin
      used_r <= d.used;
    end
    if (shift) begin
      q_r <= d;
    end
  end

  always_comb begin
    q = q_r;
    q.used = used_r;
  end
endmodule

// File: hdl/source_address_table_with_aging_unit.sv
// Source address table with lifetime aging.
// Input channel in_*: one item is an address report (cmd 0) or a lifetime
// tick (cmd 1). Result channel out_*: event items, out_tlast on the final
// result of an input item. Config channel cfg_*: index 0 aging step,
// index 1 unlimited marker; write only while idle.
// Entries sit in a ring of TABLE_DEPTH cells that, during a pass, rotates
// one place per cycle unless stalled; the head cell passes through the
// update logic on its way round. Report: a search pass; a report that
// removes, refreshes, inserts or finds the table full adds an action pass,
// then S_OUT loads the result. Silent reports end after the search pass.
// Tick: one aging pass, then S_TICK_END loads the final result once the
// result register is free. One item at a time: the next item is taken
// once the last result is.
// Tick updates are staged one deep so tlast is known when an item leaves;
// when a further update meets both a staged update and a held result, the
// ring stops rotating until the result is taken.
// Reset clears every used bit at once and the config registers to step 1,
// marker all ones. Results are held stable while out_tready is low.
module source_address_table_with_aging_unit
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata: cmd, is_ipv6, interface_index, address_high, address_low,
  //   is_present, pfx_len, preferred_life, valid_life, 5 pad
  input  logic [239:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: event_res, slot, out_is_ipv6, out_interface_index,
  //   out_address_high, out_address_low, out_pfx_len,
  //   out_preferred_life, out_valid_life
  output logic [239:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_ACT, S_TICK_END, S_TICK,
                            S_OUT} state_t;

  state_t state_r;
  logic [31:0] step_r, marker_r;
  logic [CntW-1:0] cnt_r;      // cells visited in this pass
  logic [IdxW-1:0] pos_r;      // slot of head cell
  entry_t key_r;
  logic present_r;
  logic hit_r, free_r;
  logic [IdxW-1:0] hit_slot_r, free_slot_r;

  // tick update waiting until we know whether another one follows
  logic pend_r;
  entry_t pend_e_r;
  logic [IdxW-1:0] pend_slot_r;

  logic out_valid_r, out_last_r;
  logic [EvW-1:0] out_ev_r;
  logic [IdxW-1:0] out_slot_r;
  entry_t out_e_r;

  entry_t ring [TABLE_DEPTH];
  entry_t head, head_new;
  logic   shift;
  cell_ctl_t ctl;

  logic [LifeW-1:0] prf_aged, vld_aged;
  logic prf_zero, vld_zero, key_eq;

  function automatic logic [LifeW-1:0] age(input logic [LifeW-1:0] l,
                                           input logic [31:0] st,
                                           input logic [31:0] mk);
    if (l == mk || l == '0) age = l;
    else if (l >= st) age = l - st;
    else age = '0;
  endfunction

  assign head = ring[0];

  assign prf_aged = age(head.prf, step_r, marker_r);
  assign vld_aged = age(head.vld, step_r, marker_r);
  assign prf_zero = (head.prf != marker_r) && (head.prf != '0) && (prf_aged == '0);
  assign vld_zero = (head.vld != marker_r) && (head.vld != '0) && (vld_aged == '0);
  assign key_eq = head.used && head.is_ipv6 == key_r.is_ipv6 && head.ifc == key_r.ifc
                  && head.hi == key_r.hi && head.lo == key_r.lo;

  logic tick_ev;
  assign tick_ev = head.used && head.is_ipv6 && (prf_zero || vld_zero);

  always_comb begin
    ctl = '0;
    case (state_r)
      S_SEARCH: begin
        ctl.rotate = 1'b1;
        ctl.do_match = 1'b1;
      end
      S_ACT: begin
        ctl.rotate = 1'b1;
        ctl.do_clear = hit_r && !present_r && (pos_r == hit_slot_r);
        ctl.do_refresh = hit_r && present_r && key_r.is_ipv6 && (pos_r == hit_slot_r);
        ctl.do_insert = !hit_r && free_r && (pos_r == free_slot_r);
      end
      S_TICK: begin
        // a second update needs either the stage or the result register free
        ctl.rotate = !(tick_ev && pend_r && out_valid_r);
        ctl.do_tick = 1'b1;
      end
      default: ctl = '0;
    endcase
  end
  assign shift = ctl.rotate;

  always_comb begin
    head_new = head;
    if (ctl.do_tick && head.used && head.is_ipv6) begin
      head_new.prf = prf_aged;
      head_new.vld = vld_aged;
    end
    if (ctl.do_clear) head_new.used = 1'b0;
    if (ctl.do_refresh) begin
      head_new.prf = key_r.prf;
      head_new.vld = key_r.vld;
    end
    if (ctl.do_insert) head_new = key_r;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t d;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = ring[g+1];
    end
    sat_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(d), .q(ring[g]));
  end

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;

  entry_t in_e;
  always_comb begin
    in_e.used = 1'b1;
    in_e.is_ipv6 = in_tdata[1];
    in_e.ifc = in_tdata[33:2];
    in_e.hi = in_tdata[1] ? in_tdata[97:34] : '0;
    in_e.lo = in_tdata[1] ? in_tdata[161:98] : {32'b0, in_tdata[129:98]};
    in_e.pfx = in_tdata[170:163];
    in_e.prf = in_tdata[1] ? in_tdata[202:171] : '0;
    in_e.vld = in_tdata[1] ? in_tdata[234:203] : '0;
  end

  logic pass_end;
  assign pass_end = shift && (cnt_r == CntW'(TABLE_DEPTH - 1));
  logic out_take;
  assign out_take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= 32'd1;
      marker_r <= '1;
      cnt_r <= '0;
      pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_AGING_STEP) step_r <= cfg_data;
        else marker_r <= cfg_data;
      end
      if (out_take) out_valid_r <= 1'b0;
      if (shift) begin
        pos_r <= (pos_r == IdxW'(TABLE_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        cnt_r <= pass_end ? '0 : cnt_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            key_r <= in_e;
            present_r <= in_tdata[162];
            hit_r <= 1'b0;
            free_r <= 1'b0;
            pend_r <= 1'b0;
            state_r <= (in_tdata[0] == CMD_TICK) ? S_TICK : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (key_eq && !hit_r) begin
            hit_r <= 1'b1;
            hit_slot_r <= pos_r;
          end
          if (!head.used && !free_r) begin
            free_r <= 1'b1;
            free_slot_r <= pos_r;
          end
          if (pass_end) begin
            if ((hit_r || key_eq) ? (!present_r || key_r.is_ipv6)
                                  : present_r)
              state_r <= S_ACT;
            else
              state_r <= S_IDLE;
          end
        end
        S_ACT: begin
          if (ctl.do_clear || ctl.do_refresh || ctl.do_insert) begin
            out_e_r <= head_new;
            out_slot_r <= pos_r;
            out_ev_r <= ctl.do_clear ? EV_REMOVED :
                        (ctl.do_refresh ? EV_UPDATED : EV_NEW);
          end
          if (pass_end) begin
            if (!hit_r && !free_r) begin
              out_e_r <= key_r;
              out_slot_r <= '0;
              out_ev_r <= EV_FULL;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_TICK: begin
          // a new update releases the staged one, which then is not last
          if (shift && tick_ev) begin
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_e_r <= pend_e_r;
              out_slot_r <= pend_slot_r;
              out_ev_r <= EV_UPDATED;
              out_last_r <= 1'b0;
            end
            pend_r <= 1'b1;
            pend_e_r <= head_new;
            pend_slot_r <= pos_r;
          end
          if (pass_end) begin
            state_r <= S_TICK_END;
          end
        end
        S_TICK_END: begin
          // end of tick: staged update goes out as last, or the quiet result
          if (!out_valid_r) begin
            if (pend_r) begin
              out_e_r <= pend_e_r;
              out_slot_r <= pend_slot_r;
              out_ev_r <= EV_UPDATED;
            end else begin
              out_e_r <= '0;
              out_slot_r <= '0;
              out_ev_r <= EV_NONE;
            end
            pend_r <= 1'b0;
            out_valid_r <= 1'b1;
            out_last_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {out_e_r.vld, out_e_r.prf, out_e_r.pfx, out_e_r.lo,
                      out_e_r.hi, out_e_r.ifc, out_e_r.is_ipv6,
                      SlotW'(out_slot_r), out_ev_r};
endmodule

// File: hdl/sat_checker.sv
module sat_checker
  import sat_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic [239:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[EvW-1:0] == EV_NONE |-> out_tlast)
    else $error("none result not last");
endmodule

bind source_address_table_with_aging_unit sat_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
  .out_tdata(out_tdata));

// File: tb/sv/source_address_table_with_aging_unit_tb.sv
module source_address_table_with_aging_unit_tb;
  import sat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth       = 16;
  localparam int PoolSize    = 24;  // more keys than slots, so the table fills
  localparam int StallLimit  = 5000;
  localparam int LongHold    = 300;
  localparam int SettleIdle  = 40;  // search pass + action pass + margin

  // One address report or lifetime tick
  typedef struct packed {
    logic             cmd;
    logic             is_ipv6;
    logic [IfcW-1:0]  ifc;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
    logic             present;
    logic [PfxW-1:0]  pfx;
    logic [LifeW-1:0] prf;
    logic [LifeW-1:0] vld;
  } addr_item_t;

  // One event item as it leaves the block
  typedef struct packed {
    logic [EvW-1:0]   ev;
    logic [SlotW-1:0] slot;
    logic             is_ipv6;
    logic [IfcW-1:0]  ifc;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] lo;
    logic [PfxW-1:0]  pfx;
    logic [LifeW-1:0] prf;
    logic [LifeW-1:0] vld;
    logic             last;
  } sat_event_t;

  // Directed row: item plus, where obvious, the first event it must give
  typedef struct {
    addr_item_t     item;
    bit             has_ev;
    logic [EvW-1:0] ev;
  } directed_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // in_tdata: cmd, is_ipv6, interface_index, address_high, address_low,
  //   is_present, pfx_len, preferred_life, valid_life, pad
  logic [239:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // out_tdata: event_res, slot, out_is_ipv6, out_interface_index,
  //   out_address_high, out_address_low, out_pfx_len,
  //   out_preferred_life, out_valid_life
  logic [239:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  source_address_table_with_aging_unit #(.TABLE_DEPTH(Depth)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow table and config, updated as items are accepted
  // ---------------------------------------------------------------
  logic [LifeW-1:0] shadow_step;
  logic [LifeW-1:0] shadow_marker;
  logic             sh_used [Depth];
  logic             sh_v6   [Depth];
  logic [IfcW-1:0]  sh_ifc  [Depth];
  logic [AddrW-1:0] sh_hi   [Depth];
  logic [AddrW-1:0] sh_lo   [Depth];
  logic [PfxW-1:0]  sh_pfx  [Depth];
  logic [LifeW-1:0] sh_prf  [Depth];
  logic [LifeW-1:0] sh_vld  [Depth];

  sat_event_t pending_events[$];

  int n_items, n_events, n_mismatch;
  int ev_seen [5];
  bit quiet;       // no idling on either side
  bit hold_req;    // ask the receiver for one long hold-off
  bit hold_done;

  function automatic sat_event_t entry_event(input logic [EvW-1:0] ev, input int s);
    sat_event_t e;
    e = '{ev, s[SlotW-1:0], sh_v6[s], sh_ifc[s], sh_hi[s], sh_lo[s], sh_pfx[s],
          sh_prf[s], sh_vld[s], 1'b0};
    return e;
  endfunction

  // Lifetime after one tick; marker and zero stay put, underflow clamps to 0
  function automatic logic [LifeW-1:0] aged(input logic [LifeW-1:0] life);
    if (life == shadow_marker || life == '0) return life;
    if (life >= shadow_step) return life - shadow_step;
    return '0;
  endfunction

  // Pushes the events an accepted item causes; returns how many
  function automatic int predict_events(input addr_item_t it);
    logic             v6;
    logic [AddrW-1:0] hi, lo;
    logic [LifeW-1:0] prf, vld, np, nv;
    int               n, hit, free_s, first;
    sat_event_t       e;
    v6    = it.is_ipv6;
    hi    = v6 ? it.hi : '0;
    lo    = v6 ? it.lo : {32'd0, it.lo[31:0]};
    prf   = v6 ? it.prf : '0;
    vld   = v6 ? it.vld : '0;
    n     = 0;
    first = pending_events.size();
    if (it.cmd == CMD_TICK) begin
      for (int i = 0; i < Depth; i++) begin
        if (sh_used[i] && sh_v6[i]) begin
          np = aged(sh_prf[i]);
          nv = aged(sh_vld[i]);
          // an event only when a lifetime has just hit zero
          if ((np == '0 && sh_prf[i] != '0 && sh_prf[i] != shadow_marker) ||
              (nv == '0 && sh_vld[i] != '0 && sh_vld[i] != shadow_marker)) begin
            sh_prf[i] = np;
            sh_vld[i] = nv;
            pending_events.push_back(entry_event(EV_UPDATED, i));
            n++;
          end else begin
            sh_prf[i] = np;
            sh_vld[i] = nv;
          end
        end
      end
      if (n == 0) begin
        e = '0;
        e.ev = EV_NONE;
        pending_events.push_back(e);
        n = 1;
      end
      pending_events[first + n - 1].last = 1'b1;
      return n;
    end
    hit = -1;
    for (int i = Depth - 1; i >= 0; i--)
      if (sh_used[i] && sh_v6[i] == v6 && sh_ifc[i] == it.ifc && sh_hi[i] == hi &&
          sh_lo[i] == lo)
        hit = i;
    if (hit >= 0) begin
      if (!it.present) begin
        sh_used[hit] = 1'b0;
        e = entry_event(EV_REMOVED, hit);
      end else if (v6) begin
        sh_prf[hit] = prf;
        sh_vld[hit] = vld;
        e = entry_event(EV_UPDATED, hit);
      end else begin
        return 0;    // IPv4 refresh is silent
      end
    end else begin
      if (!it.present) return 0;   // removal of an unknown address
      free_s = -1;
      for (int i = Depth - 1; i >= 0; i--)
        if (!sh_used[i]) free_s = i;
      if (free_s < 0) begin
        e = '{EV_FULL, '0, v6, it.ifc, hi, lo, it.pfx, prf, vld, 1'b0};
      end else begin
        sh_used[free_s] = 1'b1;
        sh_v6[free_s]   = v6;
        sh_ifc[free_s]  = it.ifc;
        sh_hi[free_s]   = hi;
        sh_lo[free_s]   = lo;
        sh_pfx[free_s]  = it.pfx;
        sh_prf[free_s]  = prf;
        sh_vld[free_s]  = vld;
        e = entry_event(EV_NEW, free_s);
      end
    end
    e.last = 1'b1;
    pending_events.push_back(e);
    return 1;
  endfunction

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  function automatic logic [239:0] pack_item(input addr_item_t it);
    return {5'd0, it.vld, it.prf, it.pfx, it.present, it.lo, it.hi, it.ifc,
            it.is_ipv6, it.cmd};
  endfunction

  // Drives one item and returns at the falling edge after it is taken.
  // tvalid stays high so the next item is offered at once, unless a random gap drops it.
  task automatic send_item(input addr_item_t it, output int n_pred);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tdata  = pack_item(it);
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_pred = predict_events(it);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain_events();
    in_tvalid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // a silent item may still be walking the ring
    repeat (SettleIdle) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    drain_events();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_AGING_STEP) shadow_step = val;
    else shadow_marker = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Key pool so reports hit existing entries
  logic             key_v6  [PoolSize];
  logic [IfcW-1:0]  key_ifc [PoolSize];
  logic [AddrW-1:0] key_hi  [PoolSize];
  logic [AddrW-1:0] key_lo  [PoolSize];

  function automatic logic [LifeW-1:0] pick_life();
    case ($urandom_range(0, 9))
      0: return shadow_marker;
      1: return '0;
      2: return $urandom;
      default: return LifeW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic addr_item_t any_item();
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    return addr_item_t'(raw[$bits(addr_item_t)-1:0]);
  endfunction

  function automatic addr_item_t pool_report(input bit present);
    addr_item_t it;
    int k;
    k = $urandom_range(0, PoolSize - 1);
    it = any_item();   // unused bits keep random junk
    it.cmd     = CMD_REPORT;
    it.is_ipv6 = key_v6[k];
    it.ifc     = key_ifc[k];
    it.hi      = key_v6[k] ? key_hi[k] : {32'd0, 32'($urandom)};
    it.lo      = key_v6[k] ? key_lo[k] : {32'($urandom), key_lo[k][31:0]};
    it.present = present;
    it.pfx     = PfxW'($urandom_range(0, 128));
    it.prf     = pick_life();
    it.vld     = pick_life();
    return it;
  endfunction

  function automatic addr_item_t tick_item();
    addr_item_t it;
    it = any_item();
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic addr_item_t mixed_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return pool_report(1'b1);
    if (r < 60) return pool_report(1'b0);
    if (r < 90) return tick_item();
    return any_item();
  endfunction

  task automatic run_random(input int count);
    int n;
    for (int i = 0; i < count; i++) send_item(mixed_item(), n);
  endtask

  // ---------------------------------------------------------------
  // Directed stimulus
  // ---------------------------------------------------------------
  directed_row_t rows[$];

  function automatic addr_item_t mk(input logic cmd, input logic v6, input logic [31:0] ifc,
                                    input logic [63:0] hi, input logic [63:0] lo,
                                    input logic pres, input logic [7:0] pfx,
                                    input logic [31:0] prf, input logic [31:0] vld);
    addr_item_t it;
    it = '{cmd, v6, ifc, hi, lo, pres, pfx, prf, vld};
    return it;
  endfunction

  task automatic add_row(input addr_item_t it, input bit has_ev, input logic [EvW-1:0] ev);
    directed_row_t r;
    r.item = it;
    r.has_ev = has_ev;
    r.ev = ev;
    rows.push_back(r);
  endtask

  task automatic build_rows();
    // quiet tick on an empty table
    add_row(mk(CMD_TICK, 0, '1, '1, '1, 1, '1, '1, '1), 1, EV_NONE);
    // IPv6 insert with short lifetimes, all-ones key
    add_row(mk(CMD_REPORT, 1, '1, '1, '1, 1, 8'd128, 32'd3, 32'd5), 1, EV_NEW);
    // IPv4 insert: high word and upper low bits are junk, lifetimes dropped
    add_row(mk(CMD_REPORT, 0, '0, 64'hDEAD_BEEF_0123_4567, 64'hFFFF_FFFF_C0A8_0001, 1,
               8'd24, '1, '1), 1, EV_NEW);
    // IPv4 refresh, different junk in ignored bits: silent
    add_row(mk(CMD_REPORT, 0, '0, '0, 64'h0000_0000_C0A8_0001, 1, 8'd0, 32'd9, 32'd9),
            0, EV_NONE);
    // same IPv4 address as IPv6 is a different key
    add_row(mk(CMD_REPORT, 1, '0, '0, 64'h0000_0000_C0A8_0001, 1, '0, '0, '1), 1, EV_NEW);
    // IPv6 refresh: preferred 1, valid unlimited
    add_row(mk(CMD_REPORT, 1, '1, '1, '1, 1, 8'd64, 32'd1, 32'hFFFF_FFFF), 1, EV_UPDATED);
    // tick drives preferred of slot 0 to zero
    add_row(mk(CMD_TICK, 1, '0, '0, '0, 0, '0, '0, '0), 1, EV_UPDATED);
    // tick with nothing left to expire
    add_row(mk(CMD_TICK, 0, '0, '0, '0, 0, '0, '0, '0), 1, EV_NONE);
    // removal without a match: silent
    add_row(mk(CMD_REPORT, 1, 32'd7, '0, 64'd1, 0, '0, '0, '0), 0, EV_NONE);
    // remove the IPv4 entry
    add_row(mk(CMD_REPORT, 0, '0, '0, 64'h0000_0000_C0A8_0001, 0, '0, '0, '0),
            1, EV_REMOVED);
    // reinsert reuses the lowest free slot
    add_row(mk(CMD_REPORT, 1, 32'h8000_0000, 64'h1, 64'h8000_0000_0000_0000, 1,
               8'd255, 32'd2, 32'd2), 1, EV_NEW);
    // first tick takes both lifetimes to one, the second expires them together
    add_row(mk(CMD_TICK, 0, '0, '0, '0, 0, '0, '0, '0), 1, EV_NONE);
    add_row(mk(CMD_TICK, 0, '0, '0, '0, 0, '0, '0, '0), 1, EV_UPDATED);
  endtask

  // ---------------------------------------------------------------
  // Result side: ready driver and checker
  // ---------------------------------------------------------------
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    hold_done = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done && hold == 0) begin
        hold = LongHold;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_tready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  sat_event_t got_event, want_event;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_event = {out_tdata[2:0], out_tdata[6:3], out_tdata[7], out_tdata[39:8],
                   out_tdata[103:40], out_tdata[167:104], out_tdata[175:168],
                   out_tdata[207:176], out_tdata[239:208], out_tlast};
      n_events++;
      if (got_event.ev <= EV_FULL) ev_seen[got_event.ev]++;
      if (pending_events.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected event item: %h", got_event);
      end else begin
        want_event = pending_events.pop_front();
        if (got_event !== want_event) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("event mismatch at %0t", $realtime);
            $display("  exp ev=%0d slot=%0d v6=%0d ifc=%h", want_event.ev,
                     want_event.slot, want_event.is_ipv6, want_event.ifc,
                     " hi=%h lo=%h pfx=%0d", want_event.hi, want_event.lo,
                     want_event.pfx, " prf=%h vld=%h last=%0d", want_event.prf,
                     want_event.vld, want_event.last);
            $display("  got ev=%0d slot=%0d v6=%0d ifc=%h", got_event.ev,
                     got_event.slot, got_event.is_ipv6, got_event.ifc,
                     " hi=%h lo=%h pfx=%0d", got_event.hi, got_event.lo,
                     got_event.pfx, " prf=%h vld=%h last=%0d", got_event.prf,
                     got_event.vld, got_event.last);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on any channel
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AGING_STEP;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    n_items = 0;
    n_events = 0;
    n_mismatch = 0;
    foreach (ev_seen[i]) ev_seen[i] = 0;
    shadow_step = 32'd1;
    shadow_marker = 32'hFFFF_FFFF;
    foreach (sh_used[i]) sh_used[i] = 1'b0;
    for (int k = 0; k < PoolSize; k++) begin
      key_v6[k]  = (k % 3) != 0;
      key_ifc[k] = (k % 5 == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 3));
      key_hi[k]  = {32'($urandom), 32'($urandom)};
      key_lo[k]  = {32'($urandom), 32'($urandom)};
    end
    build_rows();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed walk, reset config
    foreach (rows[r]) begin
      send_item(rows[r].item, n);
      if (rows[r].has_ev && (n == 0 ||
          pending_events[pending_events.size() - n].ev != rows[r].ev)) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("directed row %0d: predicted event differs from %0d", r, rows[r].ev);
      end else if (!rows[r].has_ev && n != 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("directed row %0d: predicted a result where none belongs", r);
      end
    end

    // fill the table, then further inserts must report full
    for (int i = 0; i < Depth + 2; i++) begin
      addr_item_t it;
      it = any_item();
      it.cmd = CMD_REPORT;
      it.present = 1'b1;
      send_item(it, n);
    end

    // largest step, marker zero: every finite lifetime dies on the first tick
    write_reg(CFG_AGING_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_UNLIMITED, 32'h0000_0000);
    run_random(30);

    // step 2, small marker; the receiver stalls while ticks pile up
    write_reg(CFG_AGING_STEP, 32'd2);
    write_reg(CFG_UNLIMITED, 32'd5);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_item(tick_item(), n);
    run_random(25);
    // sender waits for every result before going on
    drain_events();
    run_random(10);

    // back to the reset values, no idling for the tail
    write_reg(CFG_AGING_STEP, 32'd1);
    write_reg(CFG_UNLIMITED, 32'hFFFF_FFFF);
    quiet = 1'b1;
    run_random(35);

    in_tvalid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SettleIdle) @(negedge clk);

    $display("covered %0d items, %0d events (none %0d new %0d removed %0d",
             n_items, n_events, ev_seen[0], ev_seen[1], ev_seen[2],
             " updated %0d full %0d)", ev_seen[3], ev_seen[4]);
    $display("config sweep: step 1/2/max, marker 0/5/all ones; %0d mismatches", n_mismatch);
    if (n_mismatch == 0 && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
